[rtl/pbld_pkg.sv]
// Shared types and sizes for the page buffer LRU directory.
// Used by every module of the block; depends on nothing.
package pbld_pkg;

    localparam int FRAMES    = 16;
    localparam int FRAME_W   = $clog2(FRAMES);
    localparam int AGE_W     = $clog2(FRAMES);
    localparam int DB_W      = 3;
    localparam int PAGE_W    = 24;
    localparam int PAGE_BITS = 24;
    localparam int OUT_FRAME_W = 4;

    localparam logic [PAGE_W-1:0] PAGE_MASK = PAGE_W'((64'd1 << PAGE_BITS) - 64'd1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [AGE_W-1:0]   age_t;

    typedef struct packed {
        logic [DB_W-1:0]   db;
        logic [PAGE_W-1:0] page;
        logic              wr;
    } req_t;

    typedef struct packed {
        logic                   hit;
        logic [OUT_FRAME_W-1:0] frame;
        logic                   load;
        logic                   evicted;
        logic                   writeback;
        logic [DB_W-1:0]        victim_db;
        logic [PAGE_W-1:0]      victim_page;
    } res_t;

endpackage

[rtl/page_buffer_lru_directory.sv]
// Directory of a fully associative page buffer pool with true LRU replacement.
// Instantiates pbld_front, pbld_queue and pbld_back; depends on pbld_pkg.
//
// Usage:
//   Requests arrive on in_valid/in_stall with db_slot, page_number and
//   will_write; a request is taken at a clock edge with in_valid high and
//   in_stall low. Each request yields exactly one result on out_valid/out_stall
//   carrying hit, frame_index, load_needed, evicted, writeback and the victim's
//   tags (zero unless a resident page was replaced).
//   A request passes an input register and a two-entry queue, then the engine
//   walks all 16 frames one per cycle and then applies the update, which also
//   registers the result. The engine takes one request at a time through a pop
//   step, the frame walk and an update step, comparing tags through the single
//   compare port of the walk; it takes no new request until the update is done.
//   Up to three requests are held ahead of the engine before in_stall rises.
//   While out_stall is high the result holds and the engine waits in its
//   update step; the front end keeps taking requests until the queue fills.
//   Reset (rst_n low, asynchronous) frees all frames, clears dirty bits and
//   ages, and empties the queue and output register.
module page_buffer_lru_directory (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pbld_pkg::DB_W-1:0]     db_slot,
    input  logic [pbld_pkg::PAGE_W-1:0]   page_number,
    input  logic                          will_write,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit,
    output logic [pbld_pkg::OUT_FRAME_W-1:0] frame_index,
    output logic                          load_needed,
    output logic                          evicted,
    output logic                          writeback,
    output logic [pbld_pkg::DB_W-1:0]     victim_db,
    output logic [pbld_pkg::PAGE_W-1:0]   victim_page
);

    logic           push_valid;
    logic           push_ready;
    pbld_pkg::req_t push_req;
    logic           pop_valid;
    logic           pop;
    pbld_pkg::req_t pop_req;
    pbld_pkg::res_t res;

    pbld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .db_slot     (db_slot),
        .page_number (page_number),
        .will_write  (will_write),
        .push_valid  (push_valid),
        .push_req    (push_req),
        .push_ready  (push_ready)
    );

    pbld_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_req   (push_req),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_req    (pop_req),
        .pop        (pop)
    );

    pbld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (pop_valid),
        .req_in    (pop_req),
        .req_pop   (pop),
        .res_valid (out_valid),
        .res_out   (res),
        .res_stall (out_stall)
    );

    assign hit         = res.hit;
    assign frame_index = res.frame;
    assign load_needed = res.load;
    assign evicted     = res.evicted;
    assign writeback   = res.writeback;
    assign victim_db   = res.victim_db;
    assign victim_page = res.victim_page;

endmodule

[rtl/pbld_front.sv]
// Request front end: registers an incoming request and masks its page tag.
// Depends on pbld_pkg; feeds pbld_queue.
module pbld_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [pbld_pkg::DB_W-1:0]   db_slot,
    input  logic [pbld_pkg::PAGE_W-1:0] page_number,
    input  logic          will_write,
    output logic          push_valid,
    output pbld_pkg::req_t push_req,
    input  logic          push_ready
);

    logic           stage_valid_reg;
    logic           stage_valid_next;
    pbld_pkg::req_t stage_req_reg;
    logic           accept;
    logic           push;

    assign in_stall = stage_valid_reg && !push_ready;
    assign accept   = in_valid && !in_stall;
    assign push     = stage_valid_reg && push_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Trim the page tag to the configured page width on the way in
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_req_reg.db   <= db_slot;
            stage_req_reg.page <= page_number & pbld_pkg::PAGE_MASK;
            stage_req_reg.wr   <= will_write;
        end
    end

    assign push_valid = stage_valid_reg;
    assign push_req   = stage_req_reg;

endmodule

[rtl/pbld_queue.sv]
// Short request queue between the front end and the directory engine.
// Depends on pbld_pkg.
module pbld_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  pbld_pkg::req_t push_req,
    output logic           push_ready,
    output logic           pop_valid,
    output pbld_pkg::req_t pop_req,
    input  logic           pop
);

    pbld_pkg::req_t                    slot_reg [pbld_pkg::QDEPTH];
    logic [pbld_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [pbld_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [pbld_pkg::QCNT_W-1:0]       count_reg;
    logic [pbld_pkg::QCNT_W-1:0]       count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (count_reg != pbld_pkg::QCNT_W'(pbld_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

[rtl/pbld_back.sv]
// Directory engine: walks the frame table one entry per cycle, then applies
// the hit, fill or eviction and registers the result. Depends on pbld_pkg.
module pbld_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  pbld_pkg::req_t req_in,
    output logic           req_pop,
    output logic           res_valid,
    output pbld_pkg::res_t res_out,
    input  logic           res_stall
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Frame table
    logic                           fr_valid_reg [pbld_pkg::FRAMES];
    logic                           fr_dirty_reg [pbld_pkg::FRAMES];
    pbld_pkg::age_t                 fr_age_reg   [pbld_pkg::FRAMES];
    logic [pbld_pkg::DB_W-1:0]      fr_db_reg    [pbld_pkg::FRAMES];
    logic [pbld_pkg::PAGE_W-1:0]    fr_page_reg  [pbld_pkg::FRAMES];

    pbld_pkg::req_t  cur_reg;
    pbld_pkg::frame_t scan_idx_reg;

    // Walk results
    logic                           found_reg;
    pbld_pkg::frame_t               hit_idx_reg;
    pbld_pkg::age_t                 hit_age_reg;
    logic                           hit_dirty_reg;
    logic                           free_found_reg;
    pbld_pkg::frame_t               free_idx_reg;
    pbld_pkg::age_t                 best_age_reg;
    pbld_pkg::frame_t               best_idx_reg;
    logic                           best_dirty_reg;
    logic [pbld_pkg::DB_W-1:0]      best_db_reg;
    logic [pbld_pkg::PAGE_W-1:0]    best_page_reg;

    logic           res_valid_reg;
    pbld_pkg::res_t res_reg;

    logic                           out_free;
    logic                           do_update;
    logic                           scan_match;
    logic                           scan_last;
    pbld_pkg::frame_t               upd_idx;
    pbld_pkg::age_t                 upd_limit;
    logic                           upd_age_all;
    pbld_pkg::res_t                 upd_res;
    pbld_pkg::age_t                 age_next [pbld_pkg::FRAMES];

    assign out_free   = !res_valid_reg || !res_stall;
    assign req_pop    = (state_reg == ST_IDLE) && req_valid;
    assign do_update  = (state_reg == ST_UPDATE) && out_free;
    assign scan_last  = (scan_idx_reg == pbld_pkg::frame_t'(pbld_pkg::FRAMES - 1));
    assign scan_match = fr_valid_reg[scan_idx_reg]
                        && (fr_db_reg[scan_idx_reg] == cur_reg.db)
                        && (fr_page_reg[scan_idx_reg] == cur_reg.page);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Pick the frame to use and the age bound below which valid frames grow older (all valid frames on a free fill)
    always_comb
    begin
        upd_res         = '0;
        upd_age_all     = 1'b0;
        upd_limit       = hit_age_reg;
        upd_idx         = hit_idx_reg;
        if (found_reg)
        begin
            upd_res.hit = 1'b1;
        end
        else if (free_found_reg)
        begin
            upd_idx      = free_idx_reg;
            upd_age_all  = 1'b1;
            upd_res.load = 1'b1;
        end
        else
        begin
            upd_idx               = best_idx_reg;
            upd_limit             = best_age_reg;
            upd_res.load          = 1'b1;
            upd_res.evicted       = 1'b1;
            upd_res.writeback     = best_dirty_reg;
            upd_res.victim_db     = best_db_reg;
            upd_res.victim_page   = best_page_reg;
        end
        upd_res.frame = pbld_pkg::OUT_FRAME_W'(upd_idx);
    end

    always_comb
    begin
        for (int i = 0; i < pbld_pkg::FRAMES; i++)
        begin
            age_next[i] = fr_age_reg[i];
            if (fr_valid_reg[i] && (upd_age_all || (fr_age_reg[i] < upd_limit)))
            begin
                age_next[i] = fr_age_reg[i] + 1'b1;
            end
            if (pbld_pkg::frame_t'(i) == upd_idx)
            begin
                age_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < pbld_pkg::FRAMES; i++)
            begin
                fr_valid_reg[i] <= 1'b0;
                fr_dirty_reg[i] <= 1'b0;
                fr_age_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (do_update)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (do_update)
            begin
                for (int i = 0; i < pbld_pkg::FRAMES; i++)
                begin
                    fr_age_reg[i] <= age_next[i];
                end
                fr_valid_reg[upd_idx] <= 1'b1;
                fr_dirty_reg[upd_idx] <= found_reg ? (hit_dirty_reg | cur_reg.wr) : cur_reg.wr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_pop)
        begin
            cur_reg        <= req_in;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            best_age_reg   <= '0;
            best_idx_reg   <= '0;
            best_dirty_reg <= fr_dirty_reg[0];
            best_db_reg    <= fr_db_reg[0];
            best_page_reg  <= fr_page_reg[0];
        end
        else if (state_reg == ST_SCAN)
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            // Keep the first match and the first free frame
            if (scan_match && !found_reg)
            begin
                found_reg     <= 1'b1;
                hit_idx_reg   <= scan_idx_reg;
                hit_age_reg   <= fr_age_reg[scan_idx_reg];
                hit_dirty_reg <= fr_dirty_reg[scan_idx_reg];
            end
            if (!fr_valid_reg[scan_idx_reg] && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= scan_idx_reg;
            end
            // Track the oldest frame with its tags, ready for eviction
            if (fr_age_reg[scan_idx_reg] > best_age_reg)
            begin
                best_age_reg   <= fr_age_reg[scan_idx_reg];
                best_idx_reg   <= scan_idx_reg;
                best_dirty_reg <= fr_dirty_reg[scan_idx_reg];
                best_db_reg    <= fr_db_reg[scan_idx_reg];
                best_page_reg  <= fr_page_reg[scan_idx_reg];
            end
        end
        if (do_update)
        begin
            res_reg <= upd_res;
            if (!found_reg)
            begin
                fr_db_reg[upd_idx]   <= cur_reg.db;
                fr_page_reg[upd_idx] <= cur_reg.page;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_out   = res_reg;

endmodule

[bench/pbld_directory_checker.sv]
`timescale 1ns / 1ps
// Checker for the page buffer LRU directory: watches the request and result channels,
// predicts each result from its own copy of the frame table and compares.
// Depends on pbld_pkg for field widths and the result structure.
module pbld_directory_checker
    import pbld_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [DB_W-1:0]        db_slot,
    input  logic [PAGE_W-1:0]      page_number,
    input  logic                   will_write,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic                   hit,
    input  logic [OUT_FRAME_W-1:0] frame_index,
    input  logic                   load_needed,
    input  logic                   evicted,
    input  logic                   writeback,
    input  logic [DB_W-1:0]        victim_db,
    input  logic [PAGE_W-1:0]      victim_page,
    output int                     mismatch_count,
    output int                     pending_count
);

    logic              resident [FRAMES];
    logic [DB_W-1:0]   tag_db   [FRAMES];
    logic [PAGE_W-1:0] tag_page [FRAMES];
    logic              dirty    [FRAMES];
    int                recency  [FRAMES];

    res_t pending_results [$];

    initial
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            resident[i] = 1'b0;
            tag_db[i]   = '0;
            tag_page[i] = '0;
            dirty[i]    = 1'b0;
            recency[i]  = 0;
        end
        mismatch_count = 0;
        pending_count  = 0;
    end

    // Age every resident frame more recent than the given rank.
    function automatic void age_younger(input int limit);
        for (int i = 0; i < FRAMES; i++)
            if (resident[i] && recency[i] < limit)
                recency[i]++;
    endfunction

    function automatic res_t resolve_page_request(input logic [DB_W-1:0] db,
                                                  input logic [PAGE_W-1:0] page_in,
                                                  input logic wr);
        res_t              r;
        logic [PAGE_W-1:0] page;
        int                f;
        int                best;
        bit                found;
        bit                have_free;
        r         = '0;
        page      = page_in & PAGE_MASK;
        f         = 0;
        found     = 1'b0;
        have_free = 1'b0;
        for (int i = 0; i < FRAMES; i++)
            if (!found && resident[i] && tag_db[i] == db && tag_page[i] == page)
            begin
                found = 1'b1;
                f     = i;
            end
        if (found)
        begin
            r.hit = 1'b1;
            age_younger(recency[f]);
            recency[f] = 0;
            dirty[f]   = dirty[f] | wr;
        end
        else
        begin
            r.load = 1'b1;
            for (int i = 0; i < FRAMES; i++)
                if (!have_free && !resident[i])
                begin
                    have_free = 1'b1;
                    f         = i;
                end
            if (have_free)
            begin
                age_younger(FRAMES);
                resident[f] = 1'b1;
            end
            else
            begin
                // No free frame: replace the oldest one, lowest index on a tie.
                best = 0;
                for (int i = 0; i < FRAMES; i++)
                    if (recency[i] > best)
                    begin
                        best = recency[i];
                        f    = i;
                    end
                r.evicted     = 1'b1;
                r.writeback   = dirty[f];
                r.victim_db   = tag_db[f];
                r.victim_page = tag_page[f];
                age_younger(recency[f]);
            end
            tag_db[f]   = db;
            tag_page[f] = page;
            dirty[f]    = wr;
            recency[f]  = 0;
        end
        r.frame = OUT_FRAME_W'(f);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                pending_results.push_back(resolve_page_request(db_slot, page_number,
                                                               will_write));
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual frame %0h",
                             $time, frame_index);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("hit", want.hit, hit);
                    compare_field("frame_index", want.frame, frame_index);
                    compare_field("load_needed", want.load, load_needed);
                    compare_field("evicted", want.evicted, evicted);
                    compare_field("writeback", want.writeback, writeback);
                    compare_field("victim_db", want.victim_db, victim_db);
                    compare_field("victim_page", want.victim_page, victim_page);
                end
            end
            pending_count = pending_results.size();
        end
    end

endmodule

[bench/tb_page_buffer_lru_directory.sv]
`timescale 1ns / 1ps
// Top of the page buffer LRU directory bench: clock, reset, request stimulus
// and result back-pressure. Depends on pbld_pkg and pbld_directory_checker.
module tb_page_buffer_lru_directory;
    import pbld_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [DB_W-1:0]        db_slot;
    logic [PAGE_W-1:0]      page_number;
    logic                   will_write;
    logic                   out_valid;
    logic                   out_stall;
    logic                   hit;
    logic [OUT_FRAME_W-1:0] frame_index;
    logic                   load_needed;
    logic                   evicted;
    logic                   writeback;
    logic [DB_W-1:0]        victim_db;
    logic [PAGE_W-1:0]      victim_page;

    int mismatch_count;
    int pending_count;
    bit quiet;
    bit hold_req;

    logic [DB_W+PAGE_W-1:0] tag_pool [48];
    int                     pool_size;

    page_buffer_lru_directory i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .db_slot     (db_slot),
        .page_number (page_number),
        .will_write  (will_write),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .frame_index (frame_index),
        .load_needed (load_needed),
        .evicted     (evicted),
        .writeback   (writeback),
        .victim_db   (victim_db),
        .victim_page (victim_page)
    );

    pbld_directory_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .db_slot        (db_slot),
        .page_number    (page_number),
        .will_write     (will_write),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .frame_index    (frame_index),
        .load_needed    (load_needed),
        .evicted        (evicted),
        .writeback      (writeback),
        .victim_db      (victim_db),
        .victim_page    (victim_page),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one request from a falling edge and hold it until it is taken.
    task automatic issue_request(input logic [DB_W-1:0] db, input logic [PAGE_W-1:0] page,
                                 input logic wr);
        if (!quiet)
            while ($urandom_range(99) < 14)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        db_slot     <= db;
        page_number <= page;
        will_write  <= wr;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic refill_pool(input int n);
        for (int i = 0; i < n; i++)
            tag_pool[i] = {DB_W'($urandom_range(7)), PAGE_W'($urandom)};
        pool_size = n;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 14);
        end
    end

    initial
    begin
        int                     sizes [5];
        int                     sel;
        logic [DB_W+PAGE_W-1:0] tag;
        sizes       = '{10, 16, 18, 24, 40};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        db_slot     = '0;
        page_number = '0;
        will_write  = 1'b0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        pool_size   = 1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Fill from empty with extreme tags, then hit, evict dirty and clean.
        issue_request(3'd0, 24'h000000, 1'b0);
        issue_request(3'd7, 24'hFFFFFF, 1'b1);
        issue_request(3'd0, 24'h000000, 1'b1);
        issue_request(3'd7, 24'h000000, 1'b0);
        issue_request(3'd0, 24'hFFFFFF, 1'b0);
        for (int i = 4; i < FRAMES; i++)
            issue_request(DB_W'(i), PAGE_W'(i * 24'h111111), i[0]);
        issue_request(3'd3, 24'h0ABCDE, 1'b0);
        issue_request(3'd5, 24'h800000, 1'b1);
        issue_request(3'd0, 24'h000000, 1'b0);
        issue_request(3'd7, 24'hFFFFFF, 1'b0);
        issue_request(3'd5, 24'h800000, 1'b0);

        for (int n = 0; n < 1400; n++)
        begin
            if (n % 200 == 0)
                refill_pool(sizes[$urandom_range(4)]);
            if (n == 150)
                hold_req = 1'b1;
            quiet = (n >= 600 && n < 850);
            sel = $urandom_range(99);
            if (sel < 72)
                tag = tag_pool[$urandom_range(pool_size - 1)];
            else if (sel < 86)
                tag = tag_pool[$urandom_range(pool_size - 1)]
                      ^ ((DB_W+PAGE_W)'(1) << $urandom_range(DB_W + PAGE_W - 1));
            else
                tag = {DB_W'($urandom_range(7)), PAGE_W'($urandom)};
            issue_request(tag[DB_W+PAGE_W-1:PAGE_W], tag[PAGE_W-1:0],
                          $urandom_range(3) == 0);
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        while (pending_count != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
